>>> design/assert_macros.svh
// Assertion macros shared by the encoder debounce RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define RDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rde_pkg.sv
// Types and constants for the dual rotary encoder debounce block.
package rde_pkg;

  // Command codes carried on in_tuser
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_INIT = 1'b1;

  // Step event codes
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_UP   = 2'd1;
  localparam logic [1:0] EV_DOWN = 2'd2;

  // Channel codes
  localparam logic CH_MAIN = 1'b0;
  localparam logic CH_MIC  = 1'b1;

  // {old code, new code} transitions that count as a step
  localparam logic [3:0] CODE_UP   = 4'h1;
  localparam logic [3:0] CODE_DOWN = 4'hb;

  // Reset value of the debounce tick count
  localparam logic [3:0] TICKS_RST = 4'd10;

  // Post-sample view of one channel, handed to the decoder
  typedef struct packed {
    logic       ready;
    logic [1:0] stable;
    logic [1:0] confirmed;
  } chan_stat_t;

endpackage

>>> design/dual_rotary_encoder_debounce.sv
// Top level: dual rotary encoder debounce and step decoder.
//
// Input channel (in_*): one transfer per sample tick. in_tuser is the command
// (tick sample or initialise), in_tdata carries both encoders' phase pins.
// Result channel (out_*): exactly one transfer per input transfer, in order.
// out_tdata holds the step event, out_tuser the channel it came from.
// Config: cfg_wr_en writes cfg_wr_data into debounce_ticks in the same edge;
// write only while no item is in flight.
// Each item passes the input register, then the result register (out_*).
// Throughput: one item per cycle while out_tready is high; the debounce state
// of both channels is updated in one pass as an item leaves the input register.
// Reset: both channels' state clears, debounce_ticks returns to 10, and both
// stages are empty.
// Stall: while out_tready is low the result register holds; the input
// register still takes one more item, then in_tready drops until the
// result is taken.
`include "assert_macros.svh"
module dual_rotary_encoder_debounce import rde_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [1:0] main_pins, [3:2] mic_pins, [7:4] zero
  input  logic       in_tuser,    // [0] cmd
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [1:0] step_event, [7:2] zero
  output logic       out_tuser,   // [0] channel
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data  // debounce_ticks
);

  logic [3:0] ticks_r;
  logic       in_valid_r, in_valid_nxt;
  logic       cmd_r;
  logic [1:0] main_r, mic_r;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] ev_r, ev_nxt;
  logic       ch_r, ch_nxt;

  logic       out_free, adv, in_xfer;
  logic       take_main, take_mic;
  chan_stat_t main_stat, mic_stat;
  chan_stat_t sel;

  // Handshake between stages
  assign out_free  = !out_valid_r || out_tready;
  assign adv       = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;
  assign in_xfer   = in_tvalid && in_tready;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= TICKS_RST;
    end else if (cfg_wr_en) begin
      ticks_r <= cfg_wr_data;
    end
  end

  // Input register
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r  <= in_tuser;
      main_r <= in_tdata[1:0];
      mic_r  <= in_tdata[3:2];
    end
  end

  // Channels
  rde_chan u_main (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .cmd   (cmd_r),
    .pins  (main_r),
    .ticks (ticks_r),
    .take  (take_main),
    .stat  (main_stat)
  );

  rde_chan u_mic (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .cmd   (cmd_r),
    .pins  (mic_r),
    .ticks (ticks_r),
    .take  (take_mic),
    .stat  (mic_stat)
  );

  // Decode one confirmed change, main first
  assign take_main = (cmd_r == CMD_TICK) && main_stat.ready;
  assign take_mic  = (cmd_r == CMD_TICK) && !main_stat.ready && mic_stat.ready;
  assign sel       = take_main ? main_stat : mic_stat;

  always_comb begin
    ev_nxt = EV_NONE;
    ch_nxt = CH_MAIN;
    if (take_main || take_mic) begin
      case ({sel.stable, sel.confirmed})
        CODE_UP:   ev_nxt = EV_UP;
        CODE_DOWN: ev_nxt = EV_DOWN;
        default:   ev_nxt = EV_NONE;
      endcase
    end
    if (take_mic && (ev_nxt != EV_NONE)) begin
      ch_nxt = CH_MIC;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ev_r <= ev_nxt;
      ch_r <= ch_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, ev_r};
  assign out_tuser  = ch_r;

  // Checks
  `RDE_ASSERT_NOW(a_ev_code, out_valid_r, ev_r != 2'd3, "invalid step event code")
  `RDE_ASSERT_NOW(a_mic_has_ev, out_valid_r && (ch_r == CH_MIC), ev_r != EV_NONE,
                  "microphone channel reported without a step")
  `RDE_ASSERT_NOW(a_no_overrun, in_xfer && in_valid_r, adv,
                  "input register overwritten while holding an item")
  `RDE_ASSERT_NEXT(a_stall_holds, out_valid_r && !out_tready, out_valid_r && $stable(ev_r),
                   "result register changed under stall")

endmodule

>>> design/rde_chan.sv
// Debounce state and sample logic for one encoder channel.
module rde_chan import rde_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,       // item moves from input stage to result stage
  input  logic       cmd,
  input  logic [1:0] pins,
  input  logic [3:0] ticks,
  input  logic       take,      // decoder consumes this channel's change
  output chan_stat_t stat
);

  logic [1:0] stable_r,    stable_nxt;
  logic [1:0] first_r,     first_nxt;
  logic [1:0] confirmed_r, confirmed_nxt;
  logic [3:0] count_r,     count_nxt;
  logic       settling_r,  settling_nxt;
  logic       ready_r,     ready_nxt;

  // Values after sampling, before the decoder consumes a change
  logic [1:0] s_stable, s_first, s_confirmed;
  logic [3:0] s_count;
  logic       s_settling, s_ready;

  // Sample step
  always_comb begin
    s_stable    = stable_r;
    s_first     = first_r;
    s_confirmed = confirmed_r;
    s_count     = count_r;
    s_settling  = settling_r;
    s_ready     = ready_r;
    if (cmd == CMD_INIT) begin
      s_stable    = pins;
      s_first     = 2'd0;
      s_confirmed = 2'd0;
      s_count     = 4'd0;
      s_settling  = 1'b0;
      s_ready     = 1'b0;
    end else if (settling_r && (count_r != 4'd0)) begin
      // skipped sample while settling
      s_count = count_r - 4'd1;
    end else if (pins == stable_r) begin
      s_settling = 1'b0;
      s_ready    = 1'b0;
    end else if (settling_r) begin
      // confirming sample
      s_settling = 1'b0;
      if (pins != first_r) begin
        s_ready = 1'b0;
      end else begin
        s_confirmed = pins;
        s_ready     = 1'b1;
      end
    end else begin
      // new change starts settling
      s_settling = 1'b1;
      s_count    = ticks;
      s_first    = pins;
    end
  end

  assign stat = '{ready: s_ready, stable: s_stable, confirmed: s_confirmed};

  // Decode consumes the confirmed change
  always_comb begin
    stable_nxt    = s_stable;
    first_nxt     = s_first;
    confirmed_nxt = s_confirmed;
    count_nxt     = s_count;
    settling_nxt  = s_settling;
    ready_nxt     = s_ready;
    if (take) begin
      ready_nxt  = 1'b0;
      stable_nxt = s_confirmed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r    <= 2'd0;
      first_r     <= 2'd0;
      confirmed_r <= 2'd0;
      count_r     <= 4'd0;
      settling_r  <= 1'b0;
      ready_r     <= 1'b0;
    end else if (adv) begin
      stable_r    <= stable_nxt;
      first_r     <= first_nxt;
      confirmed_r <= confirmed_nxt;
      count_r     <= count_nxt;
      settling_r  <= settling_nxt;
      ready_r     <= ready_nxt;
    end
  end

endmodule

>>> test/rde_step_checker.sv
// Step checker for the dual rotary encoder debounce block: predicts and compares results.
`timescale 1ns / 1ps

module rde_step_checker import rde_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,    // [1:0] main_pins, [3:2] mic_pins, [7:4] zero
  input  logic       in_tuser,    // [0] cmd
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,   // [1:0] step_event, [7:2] zero
  input  logic       out_tuser,   // [0] channel
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  output int         fail_count,
  output int         pending,
  output int         n_results,
  output int         n_steps
);

  // Debounce state of one encoder
  typedef struct packed {
    logic [1:0] stable;
    logic [1:0] first_seen;
    logic [1:0] confirmed;
    logic [3:0] countdown;
    logic       settling;
    logic       ready;
  } enc_t;

  // One expected result transfer
  typedef struct packed {
    logic [1:0] step;
    logic       chan;
  } step_t;

  logic [3:0] ticks;
  enc_t       main_enc;
  enc_t       mic_enc;
  step_t      expected_steps[$];

  // Initialise: everything cleared, stable code takes the pins
  function automatic enc_t enc_cleared(logic [1:0] pins);
    enc_t n;
    n = '0;
    n.stable = pins;
    return n;
  endfunction

  // One sample through the debounce of a channel
  function automatic enc_t enc_sample(enc_t s, logic [1:0] pins, logic [3:0] skip);
    enc_t n;
    n = s;
    if (s.settling && s.countdown != 4'd0) begin
      n.countdown = s.countdown - 4'd1;
    end else if (pins == s.stable) begin
      n.settling = 1'b0;
      n.ready = 1'b0;
    end else if (s.settling) begin
      n.settling = 1'b0;
      if (pins != s.first_seen) begin
        n.ready = 1'b0;
      end else begin
        n.confirmed = pins;
        n.ready = 1'b1;
      end
    end else begin
      n.settling = 1'b1;
      n.countdown = skip;
      n.first_seen = pins;
    end
    return n;
  endfunction

  // Old/new code pair to step event
  function automatic logic [1:0] step_of(logic [1:0] old_code, logic [1:0] new_code);
    case ({old_code, new_code})
      CODE_UP: return EV_UP;
      CODE_DOWN: return EV_DOWN;
      default: return EV_NONE;
    endcase
  endfunction

  // Advance both encoders by one input transfer and queue the expected step
  task automatic predict_step(logic cmd, logic [1:0] main_pins, logic [1:0] mic_pins);
    step_t r;
    r.step = EV_NONE;
    r.chan = CH_MAIN;
    if (cmd == CMD_INIT) begin
      main_enc = enc_cleared(main_pins);
      mic_enc = enc_cleared(mic_pins);
    end else begin
      main_enc = enc_sample(main_enc, main_pins, ticks);
      mic_enc = enc_sample(mic_enc, mic_pins, ticks);
      // main wins; a ready mic stays pending
      if (main_enc.ready) begin
        r.step = step_of(main_enc.stable, main_enc.confirmed);
        main_enc.stable = main_enc.confirmed;
        main_enc.ready = 1'b0;
      end else if (mic_enc.ready) begin
        r.step = step_of(mic_enc.stable, mic_enc.confirmed);
        mic_enc.stable = mic_enc.confirmed;
        mic_enc.ready = 1'b0;
        if (r.step != EV_NONE) r.chan = CH_MIC;
      end
    end
    expected_steps.push_back(r);
  endtask

  // Watch all three ports at the rising edge
  always @(posedge clk) begin : watch
    step_t want;
    if (!rst_n) begin
      ticks = TICKS_RST;
      main_enc = '0;
      mic_enc = '0;
      expected_steps.delete();
      fail_count <= 0;
      n_results <= 0;
      n_steps <= 0;
    end else begin
      if (cfg_wr_en) ticks = cfg_wr_data;
      // result side first: it always belongs to an earlier input transfer
      if (out_tvalid && out_tready) begin
        n_results <= n_results + 1;
        if (expected_steps.size() == 0) begin
          $display("%0t: unexpected result: step_event %0d channel %0d",
                   $time, out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_steps.pop_front();
          if (want.step != EV_NONE) n_steps <= n_steps + 1;
          if (out_tdata !== {6'b0, want.step} || out_tuser !== want.chan) begin
            $display("%0t: mismatch: expected tdata %0d tuser %0d, got tdata %0d tuser %0d",
                     $time, want.step, want.chan, out_tdata, out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) predict_step(in_tuser, in_tdata[1:0], in_tdata[3:2]);
    end
    pending <= expected_steps.size();
  end

endmodule

>>> test/tb_dual_rotary_encoder_debounce.sv
// Testbench top for the dual rotary encoder debounce block: stimulus and verdict.
`timescale 1ns / 1ps

module tb_dual_rotary_encoder_debounce import rde_pkg::*;;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;    // [1:0] main_pins, [3:2] mic_pins, [7:4] zero
  logic       in_tuser;    // [0] cmd
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;   // [1:0] step_event, [7:2] zero
  logic       out_tuser;   // [0] channel
  logic       cfg_wr_en;
  logic [3:0] cfg_wr_data;

  int fail_count;
  int pending;
  int n_results;
  int n_steps;

  // Sender and receiver controls
  bit  calm;
  bit  hold_req;
  int  hold_left;
  int  cur_ticks;
  int  n_items;
  int  n_inits;
  int  n_settings;

  // Encoder pin generators, one per channel
  logic [1:0] gen_code[2];
  int         gen_hold[2];
  bit         gen_up[2];

  // Random phases: debounce setting, transfers, no idling
  int phase_ticks[7] = '{15, 0, 3, 1, 2, 10, 7};
  int phase_items[7] = '{60, 60, 60, 60, 60, 50, 40};
  bit phase_calm[7]  = '{0, 0, 1, 0, 0, 0, 0};

  dual_rotary_encoder_debounce dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  rde_step_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .pending    (pending),
    .n_results  (n_results),
    .n_steps    (n_steps)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #2_000_000;
    $display("FAIL dual_rotary_encoder_debounce");
    $finish;
  end

  // Receiver: random backpressure, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 40;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 35);
      end
    end
  end

  // Offer one item with random leading gaps; returns at the negedge after the transfer
  task automatic send_item(logic cmd, logic [1:0] main_pins, logic [1:0] mic_pins);
    while (!calm && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {4'b0000, mic_pins, main_pins};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    n_items++;
    if (cmd == CMD_INIT) n_inits++;
  endtask

  // Wait until every result is back, then write the debounce setting
  task automatic set_ticks(int value);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value[3:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_ticks = value;
    n_settings++;
  endtask

  // Quadrature walk with holds around the debounce time, some short holds and glitches
  task automatic next_pins(int i, output logic [1:0] pins);
    if (gen_hold[i] == 0) begin
      if ($urandom_range(99) < 15) gen_up[i] = !gen_up[i];
      if ($urandom_range(99) < 80)
        gen_code[i] = gen_up[i] ? {gen_code[i][0], ~gen_code[i][1]}
                                : {~gen_code[i][0], gen_code[i][1]};
      else
        gen_code[i] = 2'($urandom_range(3));
      if ($urandom_range(99) < 85)
        gen_hold[i] = $urandom_range(cur_ticks + 4, cur_ticks + 1);
      else
        gen_hold[i] = $urandom_range(cur_ticks + 1, 1);
    end
    gen_hold[i]--;
    pins = ($urandom_range(99) < 6) ? 2'($urandom_range(3)) : gen_code[i];
  endtask

  task automatic random_items(int count);
    logic [1:0] mp;
    logic [1:0] cp;
    logic       cmd;
    for (int k = 0; k < count; k++) begin
      cmd = ($urandom_range(99) < 3) ? CMD_INIT : CMD_TICK;
      next_pins(0, mp);
      next_pins(1, cp);
      send_item(cmd, mp, cp);
    end
  endtask

  // Main stimulus
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tuser = CMD_TICK;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 4'd0;
    calm = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    cur_ticks = TICKS_RST;
    for (int i = 0; i < 2; i++) begin
      gen_code[i] = 2'b00;
      gen_hold[i] = 0;
      gen_up[i] = 1'b1;
    end
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: confirm on the very next sample
    set_ticks(0);
    send_item(CMD_INIT, 2'b00, 2'b00);
    send_item(CMD_TICK, 2'b01, 2'b00);   // main starts settling
    send_item(CMD_TICK, 2'b01, 2'b00);   // main up
    send_item(CMD_TICK, 2'b01, 2'b01);   // mic starts settling
    send_item(CMD_TICK, 2'b01, 2'b01);   // mic up
    send_item(CMD_INIT, 2'b10, 2'b10);
    send_item(CMD_TICK, 2'b11, 2'b11);
    send_item(CMD_TICK, 2'b11, 2'b11);   // both ready: main down, mic pending
    send_item(CMD_TICK, 2'b11, 2'b11);   // pending mic down while a new settle starts
    send_item(CMD_TICK, 2'b11, 2'b11);
    send_item(CMD_TICK, 2'b10, 2'b11);
    send_item(CMD_TICK, 2'b00, 2'b11);   // confirm differs from first sample
    send_item(CMD_TICK, 2'b10, 2'b11);
    send_item(CMD_TICK, 2'b11, 2'b11);   // back to stable while settling
    send_item(CMD_TICK, 2'b00, 2'b11);
    send_item(CMD_TICK, 2'b00, 2'b11);   // 11 -> 00 changes stable, no step
    send_item(CMD_TICK, 2'b01, 2'b11);
    send_item(CMD_INIT, 2'b11, 2'b00);   // initialise mid-settle
    send_item(CMD_TICK, 2'b10, 2'b01);
    send_item(CMD_TICK, 2'b10, 2'b01);   // main wins, mic left pending
    send_item(CMD_TICK, 2'b10, 2'b00);   // mic back to stable drops its pending change

    // Random phases over several settings
    for (int p = 0; p < 7; p++) begin
      set_ticks(phase_ticks[p]);
      calm = phase_calm[p];
      random_items(phase_items[p]);
      calm = 1'b0;
      // receiver holds off while the sender keeps offering
      if (p == 3) begin
        calm = 1'b1;
        hold_req = 1'b1;
        random_items(30);
        calm = 1'b0;
      end
    end

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("Covered %0d input transfers (%0d initialise) across %0d debounce settings,",
             n_items, n_inits, n_settings);
    $display("%0d results checked, %0d of them step events.", n_results, n_steps);
    if (fail_count == 0) begin
      $display("PASS dual_rotary_encoder_debounce");
    end else begin
      $display("FAIL dual_rotary_encoder_debounce");
    end
    $finish;
  end

endmodule
